FILE: design/iee_pkg.sv
// package: types, codes and constants of the infix expression evaluator
`timescale 1ns / 1ps
package iee_pkg;
  localparam int DEF_VALUE_DEPTH    = 32;
  localparam int DEF_OPERATOR_DEPTH = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_OPEN = 3'd4
  } op_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_RD,
    S_RED,
    S_WB,
    S_FIN,
    S_OUT
  } state_t;

  // why the stacks are being reduced
  typedef enum logic [1:0] {
    RM_OP,
    RM_CLOSE,
    RM_FINAL
  } red_mode_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;
endpackage

FILE: design/iee_stream_if.sv
// interface: valid/ready channel with a generic payload
`timescale 1ns / 1ps
interface iee_stream_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/infix_expression_evaluator.sv
// top level: two-stack infix expression evaluator
//
// usage: one request on in_ch carries char_code and last_char; a request on
// out_ch carries value and status, only after a request with last_char set.
// digits build a number, + - * / ( ) drive the stacks, other codes only end
// a number. status: ok, malformed, divide by zero, stack overflow; value is
// zero unless status is ok.
// timing: a digit, '(' or ignored code is handled in S_CHAR alone; an operator
// or ')' goes on through S_RD, where the top of both stacks is fetched, since
// the stack memories have one registered read port (phase 0 issues the reads,
// 1 captures b, 2 captures a), and then to the decision in S_RED. each reduction
// adds S_WB and S_RD again; a division waits in S_WB while the divider retires
// one quotient bit per cycle. a bare number at the end goes through S_FIN, S_RD
// and S_RED before S_OUT; every reduction at the end adds as above.
// in_ch is not ready while a character is in work or a result waits.
// after the result is taken the stacks are empty for the next expression.
// reset (rst, synchronous) empties both stacks and drops any pending result.
// if the receiver stalls, the result holds on out_ch and no input is taken.
`timescale 1ns / 1ps
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int VALUE_DEPTH    = DEF_VALUE_DEPTH,
  parameter int OPERATOR_DEPTH = DEF_OPERATOR_DEPTH
) (
  input logic clk,
  input logic rst,
  iee_stream_if.sink   in_ch,
  iee_stream_if.source out_ch
);
  localparam int VW = $clog2(VALUE_DEPTH + 1);
  localparam int OW = $clog2(OPERATOR_DEPTH + 1);
  localparam int VA = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int OA = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;

  logic [31:0] vmem [VALUE_DEPTH];
  logic [2:0]  omem [OPERATOR_DEPTH];

  state_t state, state_next;
  state_t after_red;
  red_mode_t mode, mode_next;
  logic [VW-1:0] vcnt, vcnt_next;
  logic [OW-1:0] ocnt, ocnt_next;
  logic [31:0] acc, acc_next;
  logic pend, pend_next;
  status_t err, err_next;
  logic [7:0] ch, ch_next;
  logic last, last_next;
  op_t pending_op, pending_op_next;
  op_t char_op;
  logic [31:0] res_val, res_val_next;
  logic [1:0] rd_phase, rd_phase_next;
  logic [31:0] va, vb;
  logic [31:0] v_rd;
  logic [2:0] top;

  logic v_we;
  logic [VA-1:0] v_wa;
  logic [VA-1:0] v_ra;
  logic [31:0] v_wd;
  logic o_we;
  logic [OA-1:0] o_wa;
  logic [OA-1:0] o_ra;
  logic [2:0] o_wd;

  logic is_digit;
  logic may_reduce;
  logic start_red;

  alu_req_t areq;
  alu_rsp_t arsp;
  logic [2:0] aop;

  iee_alu u_alu (.clk(clk), .rst(rst), .op(aop), .req(areq), .rsp(arsp));

  // registered reads of the stack tops
  assign v_ra = (rd_phase == 2'd0) ? VA'(vcnt - VW'(1)) : VA'(vcnt - VW'(2));
  assign o_ra = OA'(ocnt - OW'(1));

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_wa] <= v_wd;
    if (o_we) omem[o_wa] <= o_wd;
    v_rd <= vmem[v_ra];
    top  <= omem[o_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vcnt  <= '0;
      ocnt  <= '0;
      acc   <= '0;
      pend  <= 1'b0;
      err   <= ST_OK;
      rd_phase <= '0;
    end else begin
      state <= state_next;
      vcnt  <= vcnt_next;
      ocnt  <= ocnt_next;
      acc   <= acc_next;
      pend  <= pend_next;
      err   <= err_next;
      rd_phase <= rd_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    ch <= ch_next;
    last <= last_next;
    pending_op <= pending_op_next;
    mode <= mode_next;
    res_val <= res_val_next;
    if (state == S_RD && rd_phase == 2'd1) vb <= v_rd;
    if (state == S_RD && rd_phase == 2'd2) va <= v_rd;
  end

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  always_comb begin
    case (ch)
      CH_PLUS:  char_op = OP_ADD;
      CH_MINUS: char_op = OP_SUB;
      CH_STAR:  char_op = OP_MUL;
      default:  char_op = OP_DIV;
    endcase
  end

  // an incoming operator first applies the top while precedence allows
  assign may_reduce = (ocnt != '0) && (top != OP_OPEN) &&
                      ((pending_op == OP_ADD) || (pending_op == OP_SUB) ||
                       (top == OP_MUL) || (top == OP_DIV));

  assign after_red = (mode == RM_FINAL) ? S_OUT : (last ? S_FIN : S_IDLE);

  always_comb begin
    state_next = state;
    mode_next = mode;
    vcnt_next = vcnt;
    ocnt_next = ocnt;
    acc_next = acc;
    pend_next = pend;
    err_next = err;
    ch_next = ch;
    last_next = last;
    pending_op_next = pending_op;
    res_val_next = res_val;
    rd_phase_next = rd_phase;
    start_red = 1'b0;
    v_we = 1'b0; v_wa = VA'(vcnt); v_wd = acc;
    o_we = 1'b0; o_wa = OA'(ocnt); o_wd = pending_op;
    areq = '0; areq.a = va; areq.b = vb;
    areq.is_div = (top == OP_DIV);
    aop = top;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    out_ch.data = {(err == ST_OK) ? res_val : 32'd0, err};

    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ch_next = in_ch.data[8:1];
          last_next = in_ch.data[0];
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        state_next = last ? S_FIN : S_IDLE;
        if (err == ST_OK) begin
          if (is_digit) begin
            acc_next = acc * 32'd10 + {24'd0, ch - CH_ZERO};
            pend_next = 1'b1;
          end else if (pend && vcnt >= VW'(VALUE_DEPTH)) begin
            pend_next = 1'b0;
            acc_next = '0;
            err_next = ST_OVERFLOW;
          end else begin
            // flush number
            if (pend) begin
              pend_next = 1'b0;
              acc_next = '0;
              v_we = 1'b1;
              vcnt_next = vcnt + VW'(1);
            end
            case (ch) inside
              CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                pending_op_next = char_op;
                mode_next = RM_OP;
                rd_phase_next = '0;
                state_next = S_RD;
              end
              CH_OPEN: begin
                if (ocnt >= OW'(OPERATOR_DEPTH)) err_next = ST_OVERFLOW;
                else begin
                  o_we = 1'b1; o_wd = OP_OPEN;
                  ocnt_next = ocnt + OW'(1);
                end
              end
              CH_CLOSE: begin
                mode_next = RM_CLOSE;
                rd_phase_next = '0;
                state_next = S_RD;
              end
              default: ;
            endcase
          end
        end
      end
      S_RD: begin
        // phase 0 issues top reads, 1 captures b, 2 captures a
        rd_phase_next = rd_phase + 2'd1;
        if (rd_phase == 2'd2) begin
          rd_phase_next = '0;
          state_next = S_RED;
        end
      end
      S_RED: begin
        unique case (mode)
          RM_OP: begin
            if (may_reduce) start_red = 1'b1;
            else begin
              state_next = after_red;
              if (ocnt >= OW'(OPERATOR_DEPTH)) err_next = ST_OVERFLOW;
              else begin
                o_we = 1'b1;
                ocnt_next = ocnt + OW'(1);
              end
            end
          end
          RM_CLOSE: begin
            if (ocnt == '0) begin
              err_next = ST_MALFORMED;
              state_next = after_red;
            end else if (top == OP_OPEN) begin
              ocnt_next = ocnt - OW'(1);
              state_next = after_red;
            end else start_red = 1'b1;
          end
          default: begin
            if (ocnt != '0) start_red = 1'b1;
            else begin
              state_next = S_OUT;
              if (vcnt != VW'(1)) err_next = ST_MALFORMED;
              else res_val_next = vb;
            end
          end
        endcase
        if (start_red) begin
          if (top == OP_OPEN || vcnt < VW'(2)) begin
            err_next = ST_MALFORMED;
            state_next = after_red;
          end else if (top == OP_DIV && vb == '0) begin
            err_next = ST_DIVZERO;
            state_next = after_red;
          end else begin
            areq.start = 1'b1;
            state_next = S_WB;
          end
        end
      end
      S_WB: begin
        if (arsp.done) begin
          v_we = 1'b1;
          v_wa = VA'(vcnt - VW'(2));
          v_wd = arsp.result;
          vcnt_next = vcnt - VW'(1);
          ocnt_next = ocnt - OW'(1);
          state_next = S_RD;
        end
      end
      S_FIN: begin
        if (err != ST_OK) state_next = S_OUT;
        else if (pend) begin
          pend_next = 1'b0;
          acc_next = '0;
          if (vcnt >= VW'(VALUE_DEPTH)) err_next = ST_OVERFLOW;
          else begin
            v_we = 1'b1;
            vcnt_next = vcnt + VW'(1);
          end
        end else begin
          mode_next = RM_FINAL;
          rd_phase_next = '0;
          state_next = S_RD;
        end
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          vcnt_next = '0;
          ocnt_next = '0;
          acc_next = '0;
          pend_next = 1'b0;
          err_next = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid));
  a_vcnt: assert property (@(posedge clk) disable iff (rst) vcnt <= VW'(VALUE_DEPTH));
  a_ocnt: assert property (@(posedge clk) disable iff (rst) ocnt <= OW'(OPERATOR_DEPTH));
endmodule

FILE: design/iee_alu.sv
// shared arithmetic unit: add, subtract, multiply with a registered result, divide bit-serially
`timescale 1ns / 1ps
module iee_alu
  import iee_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic [2:0] op,
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] ua;
  logic [31:0] ub;
  logic [31:0] comb_res;

  assign ua = req.a[31] ? (~req.a + 32'd1) : req.a;
  assign ub = req.b[31] ? (~req.b + 32'd1) : req.b;
  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_comb begin
    case (op)
      OP_ADD:  comb_res = req.a + req.b;
      OP_SUB:  comb_res = req.a - req.b;
      default: comb_res = req.a * req.b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !req.is_div) begin
        rsp.done   <= 1'b1;
        rsp.result <= comb_res;
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= ua;
        rem  <= '0;
        dvs  <= ub;
        neg  <= req.a[31] ^ req.b[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          if (!trial[32]) rsp.result <= neg ? ~{quo[30:0], 1'b1} + 32'd1 : {quo[30:0], 1'b1};
          else rsp.result <= neg ? ~{quo[30:0], 1'b0} + 32'd1 : {quo[30:0], 1'b0};
        end
      end
    end
  end
endmodule
